### hdl/spfl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and store port types for the slot pool free list.
package spfl_pkg;

  localparam int SLOTS      = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [CNT_W-1:0] LIST_EMPTY = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Write side of the slot stores, one port per store.
  typedef struct packed {
    logic                  val_we;
    logic [IDX_W-1:0]      val_addr;
    logic [VALUE_BITS-1:0] val_data;
    logic                  vld_we;
    logic [IDX_W-1:0]      vld_addr;
    logic                  vld_data;
    logic                  lnk_we;
    logic [IDX_W-1:0]      lnk_addr;
    logic [CNT_W-1:0]      lnk_data;
  } spfl_wr_t;

  // Registered read data, with same-edge writes forwarded.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  valid;
    logic [CNT_W-1:0]      link;
  } spfl_rd_t;

endpackage

### hdl/spfl_store.sv
`timescale 1ns / 1ps
// Value, valid and link stores of the slot pool, with write-to-read forwarding.
module spfl_store
  import spfl_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  logic [IDX_W-1:0] rd_link_addr_i,
  input  spfl_wr_t         wr_i,
  output spfl_rd_t         rd_o
);

  logic [VALUE_BITS-1:0] value_mem [SLOTS];
  logic                  valid_mem [SLOTS];
  logic [CNT_W-1:0]      link_mem  [SLOTS];

  logic [VALUE_BITS-1:0] value_q;
  logic                  valid_q;
  logic [CNT_W-1:0]      link_q;

  // Read old contents, but take the new word when the same edge writes it.
  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      value_mem[wr_i.val_addr] <= wr_i.val_data;
    end
    if (wr_i.val_we && (wr_i.val_addr == rd_idx_i)) begin
      value_q <= wr_i.val_data;
    end else begin
      value_q <= value_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.vld_we) begin
      valid_mem[wr_i.vld_addr] <= wr_i.vld_data;
    end
    if (wr_i.vld_we && (wr_i.vld_addr == rd_idx_i)) begin
      valid_q <= wr_i.vld_data;
    end else begin
      valid_q <= valid_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.lnk_we) begin
      link_mem[wr_i.lnk_addr] <= wr_i.lnk_data;
    end
    if (wr_i.lnk_we && (wr_i.lnk_addr == rd_link_addr_i)) begin
      link_q <= wr_i.lnk_data;
    end else begin
      link_q <= link_mem[rd_link_addr_i];
    end
  end

  assign rd_o.value = value_q;
  assign rd_o.valid = valid_q;
  assign rd_o.link  = link_q;

endmodule

### hdl/slot_pool_free_list.sv
`timescale 1ns / 1ps
// Top level of the slot pool with a free list kept inside the freed slots.
//
//   channel   direction  handshake             payload
//   request   in         start_i, busy_o       action_i, slot_index_i, item_value_i
//   result    out        done_o (one cycle)    result_index_o, read_value_o,
//                                              status_o, pool_size_o
//
// One request per cycle, sustained. A request accepted at one edge is in the
// execute stage for the next cycle, with its store reads registered at the
// accept edge; its result beat shows on done_o in the cycle after that. The
// free-head link read is the tight loop: its address comes from the next
// free head of the request in execute. Reset holds busy_o high and empties
// the pool; busy_o drops at the first edge after reset is released and
// never rises again. The receiver cannot stall, so nothing holds a result
// beat back.
module slot_pool_free_list
  import spfl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            action_i,
  input  logic [IDX_W-1:0]      slot_index_i,
  input  logic [VALUE_BITS-1:0] item_value_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      result_index_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      pool_size_o
);

  logic accept;

  // Control state.
  logic             busy_q;
  logic             ex_vld_q;
  logic             done_q;
  logic [CNT_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] high_water_q, high_water_d;

  // Execute-stage payload.
  action_e               ex_act_q;
  logic [IDX_W-1:0]      ex_idx_q;
  logic [VALUE_BITS-1:0] ex_val_q;

  // Result registers.
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  status_e               status_q, status_d;
  logic [CNT_W-1:0]      pool_q;

  spfl_wr_t wr;
  spfl_rd_t rd;
  logic     live;

  assign accept = start_i && !busy_q;

  spfl_store u_store (
    .clk_i          (clk_i),
    .rd_idx_i       (slot_index_i),
    .rd_link_addr_i (free_head_d[IDX_W-1:0]),
    .wr_i           (wr),
    .rd_o           (rd)
  );

  // A slot is live only below the high-water mark; at or above it the valid mark
  // may be stale from before a clear, or never written at all.
  assign live = ({1'b0, ex_idx_q} < high_water_q) && rd.valid;

  always_comb begin
    free_head_d  = free_head_q;
    high_water_d = high_water_q;
    res_idx_d    = '0;
    res_val_d    = '0;
    status_d     = ST_OK;
    wr           = '0;
    wr.val_addr  = ex_idx_q;
    wr.val_data  = ex_val_q;
    wr.vld_addr  = ex_idx_q;
    wr.lnk_addr  = ex_idx_q;
    wr.lnk_data  = free_head_q;
    if (ex_vld_q) begin
      unique case (ex_act_q)
        ACT_INSERT: begin
          if (free_head_q < LIST_EMPTY) begin
            // Pop the head: its link was read at the head address.
            res_idx_d   = free_head_q[IDX_W-1:0];
            free_head_d = (rd.link > LIST_EMPTY) ? LIST_EMPTY : rd.link;
          end else if (high_water_q < LIST_EMPTY) begin
            res_idx_d    = high_water_q[IDX_W-1:0];
            high_water_d = high_water_q + CNT_W'(1);
          end else begin
            status_d = ST_FULL;
          end
          if (status_d == ST_OK) begin
            wr.val_we   = 1'b1;
            wr.val_addr = res_idx_d;
            wr.vld_we   = 1'b1;
            wr.vld_addr = res_idx_d;
            wr.vld_data = 1'b1;
          end
        end
        ACT_ERASE: begin
          if (live) begin
            // Push the slot: it links to the old head.
            wr.lnk_we   = 1'b1;
            wr.vld_we   = 1'b1;
            wr.vld_data = 1'b0;
            free_head_d = {1'b0, ex_idx_q};
          end else begin
            status_d = ST_INVALID;
          end
        end
        ACT_READ: begin
          if (live) begin
            res_val_d = rd.value;
          end else begin
            status_d = ST_INVALID;
          end
        end
        ACT_CLEAR: begin
          high_water_d = '0;
          free_head_d  = LIST_EMPTY;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b1;
      ex_vld_q     <= 1'b0;
      done_q       <= 1'b0;
      free_head_q  <= LIST_EMPTY;
      high_water_q <= '0;
    end else begin
      busy_q       <= 1'b0;
      ex_vld_q     <= accept;
      done_q       <= ex_vld_q;
      free_head_q  <= free_head_d;
      high_water_q <= high_water_d;
    end
  end

  // Payload: load on accept, hold the result beat fields while idle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_act_q <= action_e'(action_i);
      ex_idx_q <= slot_index_i;
      ex_val_q <= item_value_i;
    end
    if (ex_vld_q) begin
      res_idx_q <= res_idx_d;
      res_val_q <= res_val_d;
      status_q  <= status_d;
      pool_q    <= high_water_d;
    end
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign result_index_o = res_idx_q;
  assign read_value_o   = res_val_q;
  assign status_o       = status_q;
  assign pool_size_o    = pool_q;

endmodule

### hdl/spfl_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the slot pool, bound to the top level.
module spfl_checker
  import spfl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [1:0]            action_i,
  input logic                  done_o,
  input logic [IDX_W-1:0]      result_index_o,
  input logic [1:0]            status_o,
  input logic [CNT_W-1:0]      pool_size_o
);

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request gave no result beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result beat without a request");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pool_size_o <= CNT_W'(SLOTS)) && (status_o <= ST_INVALID))
    else $error("pool size or status out of range");

  a_full_only_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |->
      ((pool_size_o == CNT_W'(SLOTS)) && (result_index_o == '0)))
    else $error("pool full reported below capacity");

  a_insert_below_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_OK) && $past(action_i == ACT_INSERT, 2)) |->
      ({1'b0, result_index_o} < pool_size_o))
    else $error("inserted slot above the high-water mark");

endmodule

bind slot_pool_free_list spfl_checker u_spfl_checker (.*);
